@@ design/tssa_pkg.sv @@
// Package for the thread stack slot allocator: beat types, action and status codes,
// and the control structs passed between the top level and the slot cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tssa_pkg;

   localparam int DEFAULT_SLOT_COUNT = 8;
   localparam int ID_W = 16;
   localparam int COUNT_W = 17;
   localparam int TOP_W = 24;
   localparam int STRIDE_W = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int STATUS_W = 3;
   localparam int ACTION_W = 2;

   localparam logic [COUNT_W-1:0] ID_LIMIT = 17'h10000;
   localparam logic [TOP_W-1:0] GUARD_BYTES = 24'd16;
   localparam logic [TOP_W-1:0] TOP_RESET = 24'd16384;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd272;

   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_STRIDE = 1'd1;

   localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEVER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ID_W-1:0]     thread_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     new_id;
      logic [TOP_W-1:0]    stack_top;
      logic                all_free;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic            add_en;
      logic            remove_en;
      logic [ID_W-1:0] id;
   } cell_cmd_type;

   // rippled from cell to cell, lowest slot first
   typedef struct packed {
      logic free_seen;
      logic match_seen;
   } chain_type;

   typedef struct packed {
      logic busy;
      logic free_hit;
      logic match_hit;
   } cell_hit_type;

endpackage
`default_nettype wire

@@ design/tssa_cell.sv @@
// One stack slot: busy flag and owner id, plus its link in the priority chain.
// Depends on tssa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tssa_cell
   import tssa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire chain_type    chain_prev,
   output chain_type         chain_next,
   output cell_hit_type      hit
);

   logic            busy_ff, busy_in;
   logic [ID_W-1:0] owner_ff;
   logic            owns_id;

   assign owns_id = busy_ff && (owner_ff == cmd.id);

   // first free slot and first owner win; later cells see the token already taken
   assign hit.busy = busy_ff;
   assign hit.free_hit = !busy_ff && !chain_prev.free_seen;
   assign hit.match_hit = owns_id && !chain_prev.match_seen;
   assign chain_next.free_seen = chain_prev.free_seen || !busy_ff;
   assign chain_next.match_seen = chain_prev.match_seen || owns_id;

   always_comb begin
      busy_in = busy_ff;
      if (cmd.add_en && hit.free_hit) begin
         busy_in = 1'b1;
      end else if (cmd.remove_en && hit.match_hit) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // owner is only read while busy, so it needs no reset
   always_ff @(posedge clock) begin
      if (cmd.add_en && hit.free_hit) begin
         owner_ff <= cmd.id;
      end
   end

endmodule
`default_nettype wire

@@ design/thread_stack_slot_allocator_top.sv @@
// Top level of the thread stack slot allocator: row of slot cells, id counter,
// configuration registers and the address stage. Depends on tssa_pkg, tssa_cell.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  req_ channel (valid/ready) carries one request beat: action and thread_id.
//  rsp_ channel (valid/ready) returns exactly one result beat per request:
//  status, new_id, stack_top, all_free.
//  csr_ port writes top_address (index 0) or block_stride (index 1);
//  write only while no request is in flight.
//  At acceptance the slot chain search runs, the slot table and id counter
//  update and the request is loaded into the address stage; from there the
//  stride times slot multiply and the underflow compare go into the output
//  register. req_ready is low only while the address stage holds a request,
//  so a new request is taken while a finished result still waits in the
//  output register.
//  If the receiver stalls, the address stage holds until the output register
//  frees, and req_ready stays low meanwhile.
//  Reset (synchronous, active high) frees all slots, clears the id counter
//  and loads top_address 16384 and block_stride 272. No clearing pass.
module thread_stack_slot_allocator_top
   import tssa_pkg::*;
#(
   parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TOP_W-1:0]       csr_wdata
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int PROD_W = STRIDE_W + SLOT_W;
   localparam int OFF_W = PROD_W + 1;
   localparam int CMP_W = (OFF_W > TOP_W) ? OFF_W : TOP_W;

   logic [TOP_W-1:0]    top_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [COUNT_W-1:0]  ids_ff, ids_in;

   logic                accept;
   cell_cmd_type        cmd;
   chain_type           chain [SLOT_COUNT+1];
   cell_hit_type        hits [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] free_vec, match_vec, busy_vec;
   logic [SLOT_W-1:0]   free_idx, match_idx;

   logic                ids_left, id_known, any_free, any_match;
   logic [STATUS_W-1:0] status_in;
   logic [ID_W-1:0]     new_id_in;
   logic                lookup_in;

   logic                calc_ff;
   logic [STATUS_W-1:0] stg_status_ff;
   logic [ID_W-1:0]     stg_new_id_ff;
   logic [SLOT_W-1:0]   stg_slot_ff;
   logic                stg_lookup_ff;
   logic                advance;

   logic [PROD_W-1:0]   prod;
   logic [CMP_W-1:0]    offset;
   rsp_type             rsp_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   assign req_ready = !calc_ff;
   assign accept = req_valid && req_ready;
   assign advance = calc_ff && (!rsp_valid_ff || rsp_ready);

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= TOP_RESET;
         stride_ff <= STRIDE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TOP_ADDRESS:  top_ff <= csr_wdata;
            CSR_BLOCK_STRIDE: stride_ff <= csr_wdata[STRIDE_W-1:0];
            default:          ;
         endcase
      end
   end

   // ---- slot chain ----
   assign chain[0] = '0;

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      tssa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .chain_prev (chain[g]),
         .chain_next (chain[g+1]),
         .hit        (hits[g])
      );
      assign free_vec[g] = hits[g].free_hit;
      assign match_vec[g] = hits[g].match_hit;
      assign busy_vec[g] = hits[g].busy;
   end

   always_comb begin
      free_idx = '0;
      match_idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (free_vec[i]) free_idx = free_idx | SLOT_W'(i);
         if (match_vec[i]) match_idx = match_idx | SLOT_W'(i);
      end
   end

   assign ids_left = ids_ff < ID_LIMIT;
   assign id_known = {1'b0, req_data.thread_id} < ids_ff;
   assign any_free = chain[SLOT_COUNT].free_seen;
   assign any_match = chain[SLOT_COUNT].match_seen;

   always_comb begin
      cmd.add_en = 1'b0;
      cmd.remove_en = 1'b0;
      cmd.id = req_data.thread_id;
      status_in = ST_OK;
      new_id_in = '0;
      lookup_in = 1'b0;
      ids_in = ids_ff;
      case (req_data.action)
         ACT_ADD: begin
            cmd.id = ids_ff[ID_W-1:0];
            if (!any_free || !ids_left) begin
               status_in = ST_FULL;
            end else begin
               cmd.add_en = accept;
               new_id_in = ids_ff[ID_W-1:0];
               ids_in = ids_ff + COUNT_W'(1);
            end
         end
         ACT_REMOVE, ACT_LOOKUP: begin
            if (!id_known) begin
               status_in = ST_NEVER;
            end else if (!any_match) begin
               status_in = ST_NOT_RUNNING;
            end else if (req_data.action == ACT_REMOVE) begin
               cmd.remove_en = accept;
            end else begin
               lookup_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ids_ff <= '0;
      end else if (accept) begin
         ids_ff <= ids_in;
      end
   end

   // ---- address stage ----
   always_ff @(posedge clock) begin
      if (reset) begin
         calc_ff <= 1'b0;
      end else if (accept) begin
         calc_ff <= 1'b1;
      end else if (advance) begin
         calc_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_status_ff <= status_in;
         stg_new_id_ff <= new_id_in;
         stg_slot_ff <= match_idx;
         stg_lookup_ff <= lookup_in;
      end
   end

   assign prod = PROD_W'(stride_ff) * PROD_W'(stg_slot_ff);
   assign offset = CMP_W'(prod) + CMP_W'(GUARD_BYTES);

   always_comb begin
      rsp_in.status = stg_status_ff;
      rsp_in.new_id = stg_new_id_ff;
      rsp_in.stack_top = '0;
      rsp_in.all_free = ~|busy_vec;
      if (stg_lookup_ff) begin
         if (offset > CMP_W'(top_ff)) begin
            rsp_in.status = ST_UNDERFLOW;
         end else begin
            rsp_in.stack_top = TOP_W'(CMP_W'(top_ff) - offset);
         end
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // ---- assertions ----
   a_one_beat_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while previous one still in address stage");

   a_single_free_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(free_vec))
      else $error("more than one free slot claimed the add");

   a_single_owner: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one slot matched the thread id");

   a_id_count_bound: assert property (@(posedge clock) disable iff (reset)
      ids_ff <= ID_LIMIT)
      else $error("id counter passed its limit");

endmodule
`default_nettype wire

@@ bench/stack_slot_checker.sv @@
// Result checker for the thread stack slot allocator: tracks CSR writes, predicts
// the result beat of every request beat and compares it with what comes out.
// Depends on tssa_pkg.
`timescale 1ns / 1ps
module stack_slot_checker
   import tssa_pkg::*;
#(
   parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TOP_W-1:0]       csr_wdata,
   output int                     mismatch_count,
   output int                     results_pending
);

   localparam int NO_SLOT = -1;
   localparam int REPORT_LIMIT = 10;

   logic                slot_busy  [SLOT_COUNT];
   logic [ID_W-1:0]     slot_owner [SLOT_COUNT];
   logic [COUNT_W-1:0]  ids_issued;
   logic [TOP_W-1:0]    top_address;
   logic [STRIDE_W-1:0] block_stride;
   rsp_type             expected_rsp_q[$];

   // Applies one request to the shadow slot table and returns its result beat.
   function automatic rsp_type predict_slot_op(req_type beat);
      rsp_type     result;
      int          slot;
      int          s;
      logic [47:0] offset;
      result = '0;
      result.status = ST_OK;
      slot = NO_SLOT;
      case (beat.action)
         ACT_ADD: begin
            for (s = SLOT_COUNT - 1; s >= 0; s--)
               if (!slot_busy[s]) slot = s;
            if (slot == NO_SLOT || ids_issued >= ID_LIMIT) begin
               result.status = ST_FULL;
            end else begin
               slot_busy[slot] = 1'b1;
               slot_owner[slot] = ids_issued[ID_W-1:0];
               result.new_id = ids_issued[ID_W-1:0];
               ids_issued = ids_issued + 1'b1;
            end
         end
         ACT_REMOVE, ACT_LOOKUP: begin
            if ({1'b0, beat.thread_id} >= ids_issued) begin
               result.status = ST_NEVER;
            end else begin
               for (s = SLOT_COUNT - 1; s >= 0; s--)
                  if (slot_busy[s] && slot_owner[s] == beat.thread_id) slot = s;
               if (slot == NO_SLOT) begin
                  result.status = ST_NOT_RUNNING;
               end else if (beat.action == ACT_REMOVE) begin
                  slot_busy[slot] = 1'b0;
               end else begin
                  offset = 48'(block_stride) * 48'(slot) + 48'(GUARD_BYTES);
                  if (offset > 48'(top_address))
                     result.status = ST_UNDERFLOW;
                  else
                     result.stack_top = top_address - offset[TOP_W-1:0];
               end
            end
         end
         default: ;  // unused action code: no state change
      endcase
      result.all_free = 1'b1;
      for (s = 0; s < SLOT_COUNT; s++)
         if (slot_busy[s]) result.all_free = 1'b0;
      return result;
   endfunction

   always @(posedge clock) begin : check_beats
      rsp_type want;
      int      s;
      if (reset) begin
         for (s = 0; s < SLOT_COUNT; s++) begin
            slot_busy[s] = 1'b0;
            slot_owner[s] = '0;
         end
         ids_issued = '0;
         top_address = TOP_RESET;
         block_stride = STRIDE_RESET;
         expected_rsp_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_TOP_ADDRESS)
               top_address = csr_wdata;
            else if (csr_index == CSR_BLOCK_STRIDE)
               block_stride = csr_wdata[STRIDE_W-1:0];
         end
         // retire the oldest expectation before queuing a new one on the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result beat with nothing outstanding: status %0d new_id %0d",
                           $time, rsp_data.status, rsp_data.new_id);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%0t: mismatch (expected/actual) status %0d/%0d",
                               " new_id %0d/%0d stack_top %h/%h all_free %b/%b"},
                              $time, want.status, rsp_data.status,
                              want.new_id, rsp_data.new_id,
                              want.stack_top, rsp_data.stack_top,
                              want.all_free, rsp_data.all_free);
               end
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.insert(expected_rsp_q.size(), predict_slot_op(req_data));
      end
      results_pending = expected_rsp_q.size();
   end

endmodule

@@ bench/testbench.sv @@
// Top of the slot allocator bench: clock, reset, request stimulus, result-side
// stalls and the verdict. Depends on tssa_pkg, stack_slot_checker and the block.
`timescale 1ns / 1ps
module testbench;
   import tssa_pkg::*;

   localparam int SLOT_COUNT = DEFAULT_SLOT_COUNT;
   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 7;
   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int REUSED_SLOT = 3;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef enum int {READY_ALWAYS, READY_TOGGLE, READY_COIN, READY_SPARSE} ready_pattern_e;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TOP_W-1:0]       csr_wdata = '0;

   int   mismatch_count;
   int   results_pending;
   int   hold_requests = 0;
   logic free_run = 1'b0;
   int   idle_cycles = 0;

   // ids seen running or freed, learned from result beats; steers the stimulus
   req_type         in_flight_q[$];
   logic [ID_W-1:0] running_ids[$];
   logic [ID_W-1:0] retired_ids[$];
   int              ids_seen = 0;

   thread_stack_slot_allocator_top #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   stack_slot_checker #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : track_running_threads
      req_type sent;
      int      idx;
      if (reset) begin
         in_flight_q.delete();
         running_ids.delete();
         retired_ids.delete();
      end else begin
         if (rsp_valid && rsp_ready && in_flight_q.size() > 0) begin
            sent = in_flight_q.pop_front();
            if (rsp_data.status == ST_OK && sent.action == ACT_ADD) begin
               running_ids = {running_ids, rsp_data.new_id};
               if (int'(rsp_data.new_id) + 1 > ids_seen) ids_seen = int'(rsp_data.new_id) + 1;
            end else if (rsp_data.status == ST_OK && sent.action == ACT_REMOVE) begin
               for (idx = running_ids.size() - 1; idx >= 0; idx--)
                  if (running_ids[idx] == sent.thread_id) running_ids.delete(idx);
               retired_ids = {retired_ids, sent.thread_id};
               if (retired_ids.size() > 16) void'(retired_ids.pop_front());
            end
         end
         if (req_valid && req_ready) in_flight_q = {in_flight_q, req_data};
      end
   end

   // Result side: changing stall patterns, plus long hold-offs on request.
   initial begin : receiver
      int             holds_done;
      int             stretch_left;
      ready_pattern_e pattern;
      holds_done = 0;
      stretch_left = 0;
      pattern = READY_ALWAYS;
      forever begin
         @(negedge clock);
         if (holds_done < hold_requests) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (free_run) begin
            rsp_ready <= 1'b1;
         end else begin
            if (stretch_left == 0) begin
               pattern = ready_pattern_e'($urandom_range(0, 3));
               stretch_left = $urandom_range(1, 40);
            end
            stretch_left--;
            case (pattern)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_TOGGLE: rsp_ready <= ~rsp_ready;
               READY_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
               default:      rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic req_type make_beat(logic [ACTION_W-1:0] action,
                                         logic [ID_W-1:0] thread_id);
      req_type beat;
      beat.action = action;
      beat.thread_id = thread_id;
      return beat;
   endfunction

   // Mostly well-formed traffic: removes and lookups aim at running or freed ids.
   function automatic req_type make_request(int add_pct);
      req_type beat;
      int      pick;
      beat.thread_id = ID_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < add_pct) begin
         beat.action = ACT_ADD;
      end else if (pick >= 96) begin
         beat.action = ACT_UNUSED;
      end else begin
         beat.action = (pick < add_pct + (100 - add_pct) * 2 / 5) ? ACT_REMOVE : ACT_LOOKUP;
         pick = $urandom_range(0, 99);
         if (pick < 60 && running_ids.size() > 0)
            beat.thread_id = running_ids[$urandom_range(0, running_ids.size() - 1)];
         else if (pick < 75 && retired_ids.size() > 0)
            beat.thread_id = retired_ids[$urandom_range(0, retired_ids.size() - 1)];
         else if (pick < 88)
            beat.thread_id = ID_W'(ids_seen + $urandom_range(0, 3));
      end
      return beat;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_beat(input req_type beat);
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic run_random(int count, int add_pct);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < count) begin
            send_beat(make_request(add_pct));
            burst--;
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [TOP_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [TOP_W-1:0] top_address,
                            input logic [STRIDE_W-1:0] block_stride);
      drain();
      write_csr(CSR_TOP_ADDRESS, top_address);
      write_csr(CSR_BLOCK_STRIDE, TOP_W'(block_stride));
   endtask

   initial begin
      int              i;
      logic [ID_W-1:0] live_ids[$];
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, full table, double remove, slot reuse
      send_beat(make_beat(ACT_LOOKUP, 16'h0000));
      send_beat(make_beat(ACT_REMOVE, 16'hFFFF));
      send_beat(make_beat(ACT_UNUSED, 16'hFFFF));
      repeat (SLOT_COUNT + 1) send_beat(make_beat(ACT_ADD, ID_W'($urandom)));
      send_beat(make_beat(ACT_LOOKUP, 16'h0000));
      send_beat(make_beat(ACT_LOOKUP, ID_W'(SLOT_COUNT - 1)));
      send_beat(make_beat(ACT_REMOVE, ID_W'(REUSED_SLOT)));
      send_beat(make_beat(ACT_REMOVE, ID_W'(REUSED_SLOT)));
      send_beat(make_beat(ACT_LOOKUP, ID_W'(REUSED_SLOT)));
      send_beat(make_beat(ACT_ADD, 16'hFFFF));
      send_beat(make_beat(ACT_LOOKUP, ID_W'(SLOT_COUNT)));
      for (i = 0; i <= SLOT_COUNT; i++)
         if (i != REUSED_SLOT) send_beat(make_beat(ACT_REMOVE, ID_W'(i)));

      run_random(150, 40);
      configure(24'hFFFFFF, 16'hFFFF);
      hold_requests <= hold_requests + 1;
      run_random(150, 50);
      configure(24'd0, 16'd0);
      run_random(120, 35);
      configure(24'd16, 16'd0);
      run_random(120, 40);
      configure(24'd1000, 16'd200);
      hold_requests <= hold_requests + 1;
      run_random(200, 45);
      repeat (2) begin
         configure(TOP_W'($urandom_range(0, 24'hFFFFFF)),
                   STRIDE_W'($urandom_range(16, 16'hFFFF)));
         run_random(150, $urandom_range(25, 50));
      end
      configure(24'hFFFFFF, 16'd16);
      run_random(100, 25);

      // empty the table, then a few edge beats at full rate
      free_run <= 1'b1;
      drain();
      live_ids = running_ids;
      for (i = 0; i < live_ids.size(); i++)
         send_beat(make_beat(ACT_REMOVE, live_ids[i]));
      drain();
      send_beat(make_beat(ACT_ADD, 16'h0000));
      send_beat(make_beat(ACT_LOOKUP, 16'hFFFF));
      send_beat(make_beat(ACT_ADD, 16'hFFFF));
      send_beat(make_beat(ACT_REMOVE, 16'hFFFF));
      send_beat(make_beat(ACT_ADD, 16'h0000));
      send_beat(make_beat(ACT_LOOKUP, 16'hFFFF));
      send_beat(make_beat(ACT_REMOVE, 16'hFFFE));
      free_run <= 1'b0;
      drain();

      if (mismatch_count == 0 && results_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ thread_stack_slot_allocator_top.f @@
design/tssa_pkg.sv
design/tssa_cell.sv
design/thread_stack_slot_allocator_top.sv
bench/stack_slot_checker.sv
bench/testbench.sv
